// ===== sv/ott_pkg.sv =====
package ott_pkg;

   // Largest supported table and its default size
   localparam int SLOTS_DEFAULT = 4;
   localparam int SLOTS_MAX     = 64;

   localparam int TID_W    = 16;
   localparam int INSTR_W  = 8;
   localparam int IBITS_W  = 4;
   localparam int ACTIVE_W = 7;
   localparam int COUNT_W  = 16;

   // Instruction bits that a reply must echo
   localparam logic [INSTR_W-1:0] INSTR_MASK = 8'h3C;

   // Request kinds
   localparam logic [1:0] REQ_OPEN  = 2'd0;
   localparam logic [1:0] REQ_REPLY = 2'd1;
   localparam logic [1:0] REQ_CLOSE = 2'd2;

   // Response status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_SLOT  = 2'd1;
   localparam logic [1:0] STATUS_UNKNOWN  = 2'd2;
   localparam logic [1:0] STATUS_MISMATCH = 2'd3;

   typedef enum logic [1:0] {
      CELL_NOP,
      CELL_ALLOC,
      CELL_CLEAR
   } cell_op_type;

   // Command broadcast to every slot cell
   typedef struct packed {
      cell_op_type          op;
      logic [TID_W-1:0]     tid;
      logic [IBITS_W-1:0]   instr_bits;
      logic                 blocking;
   } cell_cmd_type;

   // Priority chain passed from one cell to the next
   typedef struct packed {
      logic                 hit_seen;
      logic                 free_seen;
      logic [IBITS_W-1:0]   instr_bits;
      logic                 blocking;
   } chain_type;

   function automatic logic [IBITS_W-1:0] instr_bits(input logic [INSTR_W-1:0] b);
      logic [INSTR_W-1:0] m;
      m = (b & INSTR_MASK) >> 2;
      return m[IBITS_W-1:0];
   endfunction

   // Next ID after i, wrapping past max to zero
   function automatic logic [TID_W-1:0] next_tid(input logic [TID_W-1:0] i,
                                                 input logic [TID_W-1:0] max);
      return (i < max) ? i + 16'd1 : '0;
   endfunction

endpackage

// ===== sv/outstanding_transaction_tracker_core.sv =====
// Outstanding transaction tracker. A row of SLOTS slot cells holds the open
// transactions; a lookup key and a command are broadcast to every cell and a
// priority chain runs from cell 0 upwards, so the lowest free slot or the
// lowest slot holding an ID wins. Requests come in on req_ (kind in tuser),
// one result per request leaves on rsp_ (status in tuser) through an output
// register, so a new request is taken while a result still waits.
// Sequence: a request is accepted in the idle state and handled in the
// execute state. Reply, close and unknown request kinds register their result
// there and return to idle; an open with a free slot moves on to the ID
// search, testing one candidate against the whole row each cycle, and its
// result is registered as the sequencer returns to idle, where the next
// request can be taken. An open with no free slot finishes like a reply. A result
// that is not taken holds the next request in its first step.
// max_txn_id sits at byte address 0 of the csr_ port; write it only while
// the tracker is idle. active_count is kept as a running counter.
module outstanding_transaction_tracker_core #(
   parameter int SLOTS = ott_pkg::SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] cmd_instruction, [8] reply_wanted, [24:9] txn_id,
   // [32:25] reply_instruction, [39:33] zero
   input  logic [39:0] req_tdata,
   // [1:0] req_type
   input  logic [1:0]  req_tuser,
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] assigned_tid, [22:16] active_count, [23] wake_waiter,
   // [39:24] unknown_count, [55:40] mismatch_count
   output logic [55:0] rsp_tdata,
   // [1:0] status
   output logic [1:0]  rsp_tuser,
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int N_W = $clog2(SLOTS + 1);

   // sequencer states
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_EXEC   = 2'd1;
   localparam logic [1:0] ST_SEARCH = 2'd2;

   logic [1:0]                    state_ff, state_in;

   // latched request
   logic [1:0]                    type_ff, type_in;
   logic [ott_pkg::IBITS_W-1:0]   cmd_bits_ff, cmd_bits_in;
   logic [ott_pkg::IBITS_W-1:0]   rep_bits_ff, rep_bits_in;
   logic                          wanted_ff, wanted_in;
   logic [ott_pkg::TID_W-1:0]     tid_ff, tid_in;

   // ID allocation
   logic [ott_pkg::TID_W-1:0]     last_tid_ff, last_tid_in;
   logic [ott_pkg::TID_W-1:0]     cand_ff, cand_in;
   logic [N_W-1:0]                tries_ff, tries_in;

   // configuration and statistics
   logic [ott_pkg::TID_W-1:0]     max_tid_ff, max_tid_in;
   logic [ott_pkg::COUNT_W-1:0]   unknown_ff, unknown_in;
   logic [ott_pkg::COUNT_W-1:0]   mismatch_ff, mismatch_in;
   logic [ott_pkg::ACTIVE_W-1:0]  active_ff, active_in;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [55:0]                   rsp_data_ff, rsp_data_in;
   logic [1:0]                    rsp_status_ff, rsp_status_in;

   // result being formed this cycle
   logic                          load;
   logic [1:0]                    res_status;
   logic [ott_pkg::TID_W-1:0]     res_tid;
   logic                          res_wake;

   logic                          req_accept;
   logic                          out_free;
   logic                          csr_write;

   logic [ott_pkg::TID_W-1:0]     key;
   ott_pkg::cell_cmd_type         cell_cmd;
   ott_pkg::chain_type            chain [SLOTS+1];
   ott_pkg::chain_type            chain_end;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   // config port: one register, decoded on the word address bit
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? {16'd0, max_tid_ff} : 32'd0;
   assign max_tid_in = (csr_write && (csr_paddr[2] == 1'b0)) ?
                       csr_pwdata[ott_pkg::TID_W-1:0] : max_tid_ff;

   // the row compares against the candidate while searching, else the request ID
   assign key = (state_ff == ST_SEARCH) ? cand_ff : tid_ff;

   assign chain[0] = '0;

   for (genvar s = 0; s < SLOTS; s++) begin : g_slot
      ott_slot_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .key       (key),
         .cmd       (cell_cmd),
         .chain_in  (chain[s]),
         .chain_out (chain[s+1])
      );
   end

   assign chain_end = chain[SLOTS];

   always_comb begin
      state_in    = state_ff;
      type_in     = type_ff;
      cmd_bits_in = cmd_bits_ff;
      rep_bits_in = rep_bits_ff;
      wanted_in   = wanted_ff;
      tid_in      = tid_ff;
      last_tid_in = last_tid_ff;
      cand_in     = cand_ff;
      tries_in    = tries_ff;
      unknown_in  = unknown_ff;
      mismatch_in = mismatch_ff;
      active_in   = active_ff;

      cell_cmd            = '0;
      cell_cmd.op         = ott_pkg::CELL_NOP;
      cell_cmd.instr_bits = cmd_bits_ff;
      cell_cmd.blocking   = wanted_ff;

      load       = 1'b0;
      res_status = ott_pkg::STATUS_OK;
      res_tid    = '0;
      res_wake   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               type_in     = req_tuser;
               cmd_bits_in = ott_pkg::instr_bits(req_tdata[7:0]);
               wanted_in   = req_tdata[8];
               tid_in      = req_tdata[24:9];
               rep_bits_in = ott_pkg::instr_bits(req_tdata[32:25]);
               state_in    = ST_EXEC;
            end
         end

         ST_EXEC: begin
            if (out_free) begin
               case (type_ff)
                  ott_pkg::REQ_OPEN: begin
                     if (!chain_end.free_seen) begin
                        res_status = ott_pkg::STATUS_NO_SLOT;
                        load       = 1'b1;
                        state_in   = ST_IDLE;
                     end else begin
                        cand_in  = ott_pkg::next_tid(last_tid_ff, max_tid_ff);
                        tries_in = '0;
                        state_in = ST_SEARCH;
                     end
                  end
                  ott_pkg::REQ_REPLY: begin
                     if (!chain_end.hit_seen) begin
                        unknown_in = unknown_ff + 16'd1;
                        res_status = ott_pkg::STATUS_UNKNOWN;
                     end else if (chain_end.instr_bits != rep_bits_ff) begin
                        mismatch_in = mismatch_ff + 16'd1;
                        res_status  = ott_pkg::STATUS_MISMATCH;
                     end else begin
                        res_wake = chain_end.blocking;
                     end
                     load     = 1'b1;
                     state_in = ST_IDLE;
                  end
                  ott_pkg::REQ_CLOSE: begin
                     if (!chain_end.hit_seen) begin
                        res_status = ott_pkg::STATUS_UNKNOWN;
                     end else begin
                        cell_cmd.op = ott_pkg::CELL_CLEAR;
                        active_in   = active_ff - 7'd1;
                     end
                     load     = 1'b1;
                     state_in = ST_IDLE;
                  end
                  default: begin
                     load     = 1'b1;
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_SEARCH: begin
            // a free candidate is taken; back at the last ID, or out of tries: reuse the last ID
            if ((cand_ff == last_tid_ff) || !chain_end.hit_seen ||
                (tries_ff == N_W'(SLOTS))) begin
               if (out_free) begin
                  if ((cand_ff != last_tid_ff) && !chain_end.hit_seen) begin
                     last_tid_in = cand_ff;
                  end
                  cell_cmd.op  = ott_pkg::CELL_ALLOC;
                  cell_cmd.tid = last_tid_in;
                  active_in    = active_ff + 7'd1;
                  res_tid      = last_tid_in;
                  load         = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               cand_in  = ott_pkg::next_tid(cand_ff, max_tid_ff);
               tries_in = tries_ff + N_W'(1);
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      if (load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status;
         rsp_data_in   = {mismatch_in, unknown_in, res_wake, active_in, res_tid};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_tid_ff  <= '0;
         max_tid_ff   <= 16'hFFFF;
         unknown_ff   <= '0;
         mismatch_ff  <= '0;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_tid_ff  <= last_tid_in;
         max_tid_ff   <= max_tid_in;
         unknown_ff   <= unknown_in;
         mismatch_ff  <= mismatch_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff       <= type_in;
      cmd_bits_ff   <= cmd_bits_in;
      rep_bits_ff   <= rep_bits_in;
      wanted_ff     <= wanted_in;
      tid_ff        <= tid_in;
      cand_ff       <= cand_in;
      tries_ff      <= tries_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

// ===== sv/ott_slot_cell.sv =====
module ott_slot_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [ott_pkg::TID_W-1:0]  key,
   input  ott_pkg::cell_cmd_type      cmd,
   input  ott_pkg::chain_type         chain_in,
   output ott_pkg::chain_type         chain_out
);

   logic                          valid_ff, valid_in;
   logic [ott_pkg::TID_W-1:0]     tid_ff, tid_in;
   logic [ott_pkg::IBITS_W-1:0]   ibits_ff, ibits_in;
   logic                          blocking_ff, blocking_in;

   logic hit;
   logic sel_hit;
   logic sel_free;

   assign hit      = valid_ff && (tid_ff == key);
   assign sel_hit  = hit && !chain_in.hit_seen;
   assign sel_free = !valid_ff && !chain_in.free_seen;

   always_comb begin
      chain_out.hit_seen   = chain_in.hit_seen | hit;
      chain_out.free_seen  = chain_in.free_seen | !valid_ff;
      chain_out.instr_bits = sel_hit ? ibits_ff : chain_in.instr_bits;
      chain_out.blocking   = sel_hit ? blocking_ff : chain_in.blocking;
   end

   always_comb begin
      valid_in    = valid_ff;
      tid_in      = tid_ff;
      ibits_in    = ibits_ff;
      blocking_in = blocking_ff;
      case (cmd.op)
         ott_pkg::CELL_ALLOC: begin
            if (sel_free) begin
               valid_in    = 1'b1;
               tid_in      = cmd.tid;
               ibits_in    = cmd.instr_bits;
               blocking_in = cmd.blocking;
            end
         end
         ott_pkg::CELL_CLEAR: begin
            if (sel_hit) begin
               valid_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tid_ff      <= tid_in;
      ibits_ff    <= ibits_in;
      blocking_ff <= blocking_in;
   end

endmodule

// ===== sv/ott_checker.sv =====
module ott_checker #(
   parameter int SLOTS = ott_pkg::SLOTS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // an ID is only reported for a successful request
   a_tid_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ott_pkg::STATUS_OK) |-> (rsp_tdata[15:0] == 16'd0))
      else $error("ID reported on a failed request");

   // wake-up only on a good match
   a_wake_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[23] |-> (rsp_tuser == ott_pkg::STATUS_OK))
      else $error("wake-up on a failed request");

   // occupancy never exceeds the table
   a_active_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[22:16] <= 7'(SLOTS)))
      else $error("active count beyond table size");

endmodule

bind outstanding_transaction_tracker_core ott_checker #(.SLOTS(SLOTS)) u_ott_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import ott_pkg::*;

   localparam int SLOTS = SLOTS_DEFAULT;

   // Request kind outside the defined set; the tracker must ignore it
   localparam logic [1:0] REQ_UNDEF = 2'd3;

   // Register map of the csr_ port
   localparam logic [2:0] CSR_MAX_TXN_ID = 3'd0;

   // Cycles of quiet without any handshake before the run is abandoned.
   // The slowest request is an open with full ID search, gaps
   // and stalls are short geometric runs, the phase pause is DRAIN_CYCLES.
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 2 * (SLOTS + 3) + 4;
   localparam int PHASE_REQUESTS = 185;

   // One response as the tracker should produce it
   typedef struct packed {
      logic [1:0]          status;
      logic [TID_W-1:0]    assigned;
      logic [ACTIVE_W-1:0] active;
      logic                wake;
      logic [COUNT_W-1:0]  unknowns;
      logic [COUNT_W-1:0]  mismatches;
   } outcome_type;

   // One row of the directed stimulus table
   typedef struct packed {
      logic [1:0]         kind;
      logic [INSTR_W-1:0] cmd;
      logic               wants;
      logic [TID_W-1:0]   tid;
      logic [INSTR_W-1:0] rep;
      logic               typed;   // want below is fixed by hand
      outcome_type        want;
   } stim_row_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   // [7:0] cmd_instruction, [8] reply_wanted, [24:9] txn_id,
   // [32:25] reply_instruction, [39:33] zero
   logic [39:0] req_tdata   = '0;
   // [1:0] req_type
   logic [1:0]  req_tuser   = REQ_OPEN;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   // [15:0] assigned_tid, [22:16] active_count, [23] wake_waiter,
   // [39:24] unknown_count, [55:40] mismatch_count
   logic [55:0] rsp_tdata;
   // [1:0] status
   logic [1:0]  rsp_tuser;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   outstanding_transaction_tracker_core #(.SLOTS(SLOTS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Shadow of the slot table.  Tags, bits and blocking flags are only read
   // for live slots, so their contents before the first open do not matter.
   // ---------------------------------------------------------------------
   logic               live      [SLOTS];
   logic [TID_W-1:0]   slot_tid  [SLOTS];
   logic [IBITS_W-1:0] slot_bits [SLOTS];
   logic               slot_wait [SLOTS];
   logic [TID_W-1:0]   last_tid;
   logic [COUNT_W-1:0] unknown_tally;
   logic [COUNT_W-1:0] mismatch_tally;
   logic [TID_W-1:0]   max_tid;

   outcome_type awaited_results[$];
   outcome_type oldest;
   int          errors;
   int          idle_cycles;
   bit          steady;    // no gaps, no stalls on either side

   initial begin
      for (int s = 0; s < SLOTS; s++) begin
         live[s]      = 1'b0;
         slot_tid[s]  = '0;
         slot_bits[s] = '0;
         slot_wait[s] = 1'b0;
      end
      last_tid       = '0;
      unknown_tally  = '0;
      mismatch_tally = '0;
      max_tid        = 16'hFFFF;
      errors         = 0;
      idle_cycles    = 0;
      steady         = 1'b0;
   end

   // ID after i, wrapping past the configured maximum to zero
   function automatic logic [TID_W-1:0] step_tid(input logic [TID_W-1:0] i);
      return (i < max_tid) ? i + 16'd1 : '0;
   endfunction

   // Lowest live slot tagged with tid, -1 if none
   function automatic int holder(input logic [TID_W-1:0] tid);
      int hit;
      hit = -1;
      for (int s = SLOTS - 1; s >= 0; s--)
         if (live[s] && slot_tid[s] == tid)
            hit = s;
      return hit;
   endfunction

   // Applies one request to the shadow table and returns its response
   function automatic outcome_type track_request(input logic [1:0]         kind,
                                                 input logic [INSTR_W-1:0] cmd,
                                                 input logic               wants,
                                                 input logic [TID_W-1:0]   tid,
                                                 input logic [INSTR_W-1:0] rep);
      outcome_type        o;
      int                 free_idx;
      int                 hit;
      int                 n;
      logic [TID_W-1:0]   cand;
      logic [INSTR_W-1:0] masked;
      o        = '0;
      free_idx = -1;
      for (int s = SLOTS - 1; s >= 0; s--)
         if (!live[s])
            free_idx = s;
      hit = holder(tid);
      case (kind)
         REQ_OPEN: begin
            if (free_idx < 0) begin
               o.status = STATUS_NO_SLOT;
            end else begin
               // search stops on a free ID, after SLOTS+1 tries, or on
               // coming back round to last_tid, which is then reused
               cand = step_tid(last_tid);
               for (n = 0; n <= SLOTS && cand != last_tid; n++) begin
                  if (holder(cand) < 0)
                     last_tid = cand;
                  else
                     cand = step_tid(cand);
               end
               masked              = cmd & INSTR_MASK;
               live[free_idx]      = 1'b1;
               slot_tid[free_idx]  = last_tid;
               slot_bits[free_idx] = masked[5:2];
               slot_wait[free_idx] = wants;
               o.assigned          = last_tid;
            end
         end
         REQ_REPLY: begin
            masked = rep & INSTR_MASK;
            if (hit < 0) begin
               unknown_tally = unknown_tally + 16'd1;
               o.status      = STATUS_UNKNOWN;
            end else if (slot_bits[hit] != masked[5:2]) begin
               mismatch_tally = mismatch_tally + 16'd1;
               o.status       = STATUS_MISMATCH;
            end else begin
               o.wake = slot_wait[hit];
            end
         end
         REQ_CLOSE: begin
            if (hit < 0)
               o.status = STATUS_UNKNOWN;
            else
               live[hit] = 1'b0;
         end
         default: ;
      endcase
      for (int s = 0; s < SLOTS; s++)
         o.active = o.active + ACTIVE_W'(live[s]);
      o.unknowns   = unknown_tally;
      o.mismatches = mismatch_tally;
      return o;
   endfunction

   task automatic note_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      errors++;
      $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
   endtask

   // ---------------------------------------------------------------------
   // Request side.  Gaps are inserted before a request is offered; valid is
   // held across back-to-back requests so it is never dropped and raised in
   // the same step.
   // ---------------------------------------------------------------------
   task automatic push_request(input logic [1:0]         kind,
                               input logic [INSTR_W-1:0] cmd,
                               input logic               wants,
                               input logic [TID_W-1:0]   tid,
                               input logic [INSTR_W-1:0] rep,
                               input logic               typed,
                               input outcome_type        typed_want);
      outcome_type predicted;
      while (!steady && $urandom_range(99) < 37) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {7'd0, rep, tid, wants, cmd};
      do @(posedge clock); while (!req_tready);
      predicted = track_request(kind, cmd, wants, tid, rep);
      awaited_results.push_back(typed ? typed_want : predicted);
   endtask

   // Random request, mostly aimed at live IDs with well-formed replies.
   // Returns 0 for an undefined kind, which does not count toward a phase.
   task automatic random_request(output bit counted);
      int                 r;
      int                 pick;
      logic [1:0]         kind;
      logic [INSTR_W-1:0] cmd;
      logic [INSTR_W-1:0] rep;
      logic [TID_W-1:0]   tid;
      logic               wants;
      r     = int'($urandom_range(99));
      kind  = (r < 38) ? REQ_OPEN : (r < 70) ? REQ_REPLY : (r < 94) ? REQ_CLOSE : REQ_UNDEF;
      cmd   = 8'($urandom);
      rep   = 8'($urandom);
      tid   = 16'($urandom);
      wants = 1'($urandom_range(1));
      pick  = int'($urandom_range(SLOTS - 1));
      for (int t = 0; t < SLOTS && !live[pick]; t++)
         pick = (pick + 1) % SLOTS;
      if (live[pick] && $urandom_range(9) < 8) begin
         tid = slot_tid[pick];
         if ($urandom_range(9) < 7)
            rep = {rep[7:6], slot_bits[pick], rep[1:0]};
      end else if ($urandom_range(1)) begin
         tid = 16'($urandom_range(max_tid));
      end
      push_request(kind, cmd, wants, tid, rep, 1'b0, '0);
      counted = (kind != REQ_UNDEF);
   endtask

   // Lets every outstanding request come back, then the search latency
   task automatic drain_tracker();
      req_tvalid <= 1'b0;
      while (awaited_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes max_txn_id while idle and reads it back
   task automatic program_max(input logic [TID_W-1:0] value);
      drain_tracker();
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= CSR_MAX_TXN_ID;
      csr_pwdata  <= {16'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      max_tid = value;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== {16'd0, value})
         note_mismatch("max_txn_id read-back", csr_prdata, {16'd0, value});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Response side: random back-pressure, every response checked in order
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 37);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_results.size() == 0) begin
            note_mismatch("response with no request outstanding", rsp_tdata[31:0], 32'd0);
         end else begin
            oldest = awaited_results.pop_front();
            if (rsp_tuser !== oldest.status)
               note_mismatch("status", 32'(rsp_tuser), 32'(oldest.status));
            if (rsp_tdata[15:0] !== oldest.assigned)
               note_mismatch("assigned_tid", 32'(rsp_tdata[15:0]), 32'(oldest.assigned));
            if (rsp_tdata[22:16] !== oldest.active)
               note_mismatch("active_count", 32'(rsp_tdata[22:16]), 32'(oldest.active));
            if (rsp_tdata[23] !== oldest.wake)
               note_mismatch("wake_waiter", 32'(rsp_tdata[23]), 32'(oldest.wake));
            if (rsp_tdata[39:24] !== oldest.unknowns)
               note_mismatch("unknown_count", 32'(rsp_tdata[39:24]), 32'(oldest.unknowns));
            if (rsp_tdata[55:40] !== oldest.mismatches)
               note_mismatch("mismatch_count", 32'(rsp_tdata[55:40]),
                             32'(oldest.mismatches));
         end
      end
   end

   // Watchdog: any handshake on any port restarts the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("outstanding_transaction_tracker_core: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Directed table, default max_txn_id, straight out of reset.
   // Typed rows carry the response by hand; the rest use the predictor.
   // ---------------------------------------------------------------------
   stim_row_type directed_rows[17];

   logic [TID_W-1:0] phase_max[8];
   bit               counted;
   int               done;

   initial begin
      directed_rows = '{
         // first open after reset gets ID 1, all-zero command
         '{REQ_OPEN,  8'h00, 1'b0, 16'h0000, 8'h00, 1'b1,
           '{STATUS_OK, 16'd1, 7'd1, 1'b0, 16'd0, 16'd0}},
         // blocking open, all-ones command
         '{REQ_OPEN,  8'hFF, 1'b1, 16'hFFFF, 8'hFF, 1'b1,
           '{STATUS_OK, 16'd2, 7'd2, 1'b0, 16'd0, 16'd0}},
         // matching reply wakes the blocked opener
         '{REQ_REPLY, 8'h00, 1'b0, 16'h0002, 8'h3C, 1'b1,
           '{STATUS_OK, 16'd0, 7'd2, 1'b1, 16'd0, 16'd0}},
         // reply with the masked bits all different
         '{REQ_REPLY, 8'h00, 1'b0, 16'h0002, 8'hC3, 1'b1,
           '{STATUS_MISMATCH, 16'd0, 7'd2, 1'b0, 16'd0, 16'd1}},
         // match on a non-blocking slot, bits outside the mask ignored
         '{REQ_REPLY, 8'h00, 1'b0, 16'h0001, 8'hC3, 1'b1,
           '{STATUS_OK, 16'd0, 7'd2, 1'b0, 16'd0, 16'd1}},
         // reply to an ID nobody holds
         '{REQ_REPLY, 8'h00, 1'b0, 16'hFFFF, 8'h00, 1'b1,
           '{STATUS_UNKNOWN, 16'd0, 7'd2, 1'b0, 16'd1, 16'd1}},
         // repeated reply wakes again
         '{REQ_REPLY, 8'h00, 1'b0, 16'h0002, 8'hFF, 1'b1,
           '{STATUS_OK, 16'd0, 7'd2, 1'b1, 16'd1, 16'd1}},
         // close of an unknown ID leaves the counters alone
         '{REQ_CLOSE, 8'h00, 1'b0, 16'hFFFF, 8'h00, 1'b1,
           '{STATUS_UNKNOWN, 16'd0, 7'd2, 1'b0, 16'd1, 16'd1}},
         '{REQ_OPEN,  8'hAA, 1'b1, 16'h0000, 8'h00, 1'b0, '0},
         '{REQ_OPEN,  8'h55, 1'b0, 16'h0000, 8'h00, 1'b0, '0},
         // table full
         '{REQ_OPEN,  8'h00, 1'b1, 16'h0000, 8'h00, 1'b1,
           '{STATUS_NO_SLOT, 16'd0, 7'd4, 1'b0, 16'd1, 16'd1}},
         '{REQ_REPLY, 8'h00, 1'b0, 16'h0003, 8'h28, 1'b0, '0},
         '{REQ_CLOSE, 8'h00, 1'b0, 16'h0001, 8'h00, 1'b0, '0},
         // undefined kind with every field at its top value is ignored
         '{REQ_UNDEF, 8'hFF, 1'b1, 16'hFFFF, 8'hFF, 1'b1,
           '{STATUS_OK, 16'd0, 7'd3, 1'b0, 16'd1, 16'd1}},
         '{REQ_CLOSE, 8'h00, 1'b0, 16'h0002, 8'h00, 1'b0, '0},
         '{REQ_CLOSE, 8'h00, 1'b0, 16'h0003, 8'h00, 1'b0, '0},
         '{REQ_CLOSE, 8'h00, 1'b0, 16'h0004, 8'h00, 1'b0, '0}
      };

      // Zero and one force wrap-round and duplicate IDs; the first small
      // setting also lands below last_tid.  The random phase runs steady.
      phase_max = '{16'd0, 16'd1, 16'd3, 16'd2, 16'h0000, 16'hFFFF, 16'd6, 16'hFFFE};
      phase_max[4] = 16'($urandom);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         push_request(directed_rows[i].kind, directed_rows[i].cmd, directed_rows[i].wants,
                      directed_rows[i].tid, directed_rows[i].rep, directed_rows[i].typed,
                      directed_rows[i].want);

      foreach (phase_max[p]) begin
         program_max(phase_max[p]);
         steady = (p == 4);
         done   = 0;
         while (done < PHASE_REQUESTS) begin
            random_request(counted);
            if (counted)
               done++;
         end
      end
      steady = 1'b0;

      drain_tracker();
      if (errors == 0)
         $display("outstanding_transaction_tracker_core: match");
      else
         $display("outstanding_transaction_tracker_core: mismatch");
      $finish;
   end

endmodule
